// ----- hw/rtl/sds_pkg.sv -----
`default_nettype none

package sds_pkg;

  // fixed field widths
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned TL_W       = 9;
  localparam int unsigned TOL_W      = 16;
  localparam int unsigned REF_IDX_W  = 8;
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [TL_W-1:0] TL_RESET = 9'd256;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD   = 2'd0,
    REQ_SAMPLE = 2'd1,
    REQ_PURGE  = 2'd2,
    REQ_CHECK  = 2'd3
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMPLATE_LENGTH = 1'b0,
    REG_TOLERANCE       = 1'b1
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CLEAR  = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_RESULT = 5'b10000
  } state_e;

endpackage

`default_nettype wire

// ----- hw/rtl/sds_in_if.sv -----
`default_nettype none

interface sds_in_if import sds_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned DIST_BITS   = 48
) ();
  logic                   valid;
  logic                   ready;
  logic [REQ_W-1:0]       req_type;
  logic [REF_IDX_W-1:0]   ref_index;
  logic signed [SAMPLE_BITS-1:0] ref_value;
  logic signed [SAMPLE_BITS-1:0] sample_value;
  logic [TIME_W-1:0]      sample_time;
  logic [TIME_W-1:0]      overlap_end_time;
  logic [DIST_BITS-1:0]   threshold_dist;
  logic                   purge_all;

  modport source (
    output valid, req_type, ref_index, ref_value, sample_value, sample_time,
           overlap_end_time, threshold_dist, purge_all,
    input  ready
  );
  modport sink (
    input  valid, req_type, ref_index, ref_value, sample_value, sample_time,
           overlap_end_time, threshold_dist, purge_all,
    output ready
  );
endinterface

`default_nettype wire

// ----- hw/rtl/sds_out_if.sv -----
`default_nettype none

interface sds_out_if import sds_pkg::*; #(
  parameter int unsigned DIST_BITS = 48
) ();
  logic                 valid;
  logic                 ready;
  logic [DIST_BITS-1:0] end_dist;
  logic [TIME_W-1:0]    end_start_time;
  logic                 locally_optimal;

  modport source (
    output valid, end_dist, end_start_time, locally_optimal,
    input  ready
  );
  modport sink (
    input  valid, end_dist, end_start_time, locally_optimal,
    output ready
  );
endinterface

`default_nettype wire

// ----- hw/rtl/subsequence_dtw_spotter.sv -----
`default_nettype none
// Streaming subsequence DTW spotter (SPRING style) against a stored template.
// Channels: in_if (sink) takes one request beat: load a template entry,
// a stream sample, a purge or an optimality check. out_if (source) returns
// one result beat per request: distance and start tick at the last template
// index, plus the check flag. cfg_we_i/cfg_idx_i/cfg_wdata_i write
// template_length (index 0) and tolerance (index 1); write only when idle.
// Sample, purge and check walk the column of the template length in use
// through one shared cell pipeline (read, square, select+accumulate), one
// cell per cycle; only a sample goes on to select+accumulate, while purge
// and check act on the read data. A load skips the walk. Input ready
// returns in the cycle after the result is loaded. The memory read port
// and the single squaring multiplier set that one-cell-per-cycle pace.
// in_if.ready is high only while idle; the block takes one request at a time.
// A result sits in an output register; the next request may be taken while
// it waits, and its own result holds back until the receiver takes the first.
// Reset: template_length = 256, tolerance = 0, then a clearing pass over
// every entry sets every distance to infinity (all ones), every start tick
// to zero; in_if.ready stays low. Template entries undefined.
module subsequence_dtw_spotter import sds_pkg::*; #(
  parameter int unsigned MAX_TEMPLATE_LEN = 256,
  parameter int unsigned SAMPLE_BITS      = 16,
  parameter int unsigned DIST_BITS        = 48
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  sds_in_if.sink                     in_if,
  sds_out_if.source                  out_if
);

  localparam int unsigned AW  = $clog2(MAX_TEMPLATE_LEN);
  localparam int unsigned CW  = (AW + 1 > TL_W) ? AW + 1 : TL_W;
  localparam int unsigned SQW = 2 * SAMPLE_BITS;
  localparam int unsigned XW  = SQW + DIST_BITS;
  localparam logic [DIST_BITS-1:0]   DIST_INF = '1;
  localparam logic [SAMPLE_BITS-1:0] SMP_SIGN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [AW-1:0]          LAST_ENTRY = AW'(MAX_TEMPLATE_LEN - 1);

  // memories
  logic [SAMPLE_BITS-1:0] tmpl_mem  [MAX_TEMPLATE_LEN];
  logic [DIST_BITS-1:0]   dist_mem  [MAX_TEMPLATE_LEN];
  logic [TIME_W-1:0]      start_mem [MAX_TEMPLATE_LEN];

  // config
  logic [TL_W-1:0]  tl_q;
  logic [TOL_W-1:0] tol_q;

  // control
  state_e          state_q, state_d;
  logic [AW-1:0]   clr_q;
  logic [AW-1:0]   idx_q;
  logic [AW-1:0]   last_idx;
  logic [AW-1:0]   rd_addr;

  // per-request operands
  logic [REQ_W-1:0]       op_q;
  logic [SAMPLE_BITS-1:0] x_q;
  logic [TIME_W-1:0]      t_q;
  logic [TIME_W-1:0]      tend_q;
  logic [DIST_BITS-1:0]   bar_q;
  logic                   all_q;
  logic                   found_q;
  logic                   opt_q;

  // registered read data
  logic [SAMPLE_BITS-1:0] rd_tmpl_q;
  logic [DIST_BITS-1:0]   rd_dist_q;
  logic [TIME_W-1:0]      rd_start_q;

  // stage B (read data valid)
  logic          s1_vld_q;
  logic [AW-1:0] s1_idx_q;
  logic          s1_first_q;

  // stage C (select and accumulate)
  logic                 s2_vld_q;
  logic [AW-1:0]        s2_idx_q;
  logic                 s2_first_q;
  logic [DIST_BITS-1:0] s2_sq_q;
  logic [DIST_BITS-1:0] s2_c_d_q;
  logic [TIME_W-1:0]    s2_c_s_q;
  logic                 s2_c_diag_q;

  // carried cells
  logic [DIST_BITS-1:0] diag_d_q;
  logic [TIME_W-1:0]    diag_s_q;
  logic [DIST_BITS-1:0] up_d_q;
  logic [TIME_W-1:0]    up_s_q;

  // output register
  logic                 out_vld_q;
  logic [DIST_BITS-1:0] out_dist_q;
  logic [TIME_W-1:0]    out_start_q;
  logic                 out_opt_q;

  logic in_fire;
  logic load_ok;
  logic out_load;

  // ---------------- template length in use -----------------------------------
  logic [CW-1:0] tl_ext;
  always_comb begin
    tl_ext = CW'(tl_q);
    if (tl_ext == '0) begin
      last_idx = '0;
    end else if (tl_ext > CW'(MAX_TEMPLATE_LEN)) begin
      last_idx = LAST_ENTRY;
    end else begin
      last_idx = AW'(tl_ext - CW'(1));
    end
  end

  // ---------------- config port ----------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tl_q  <= TL_RESET;
      tol_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_TEMPLATE_LENGTH: tl_q  <= cfg_wdata_i[TL_W-1:0];
        REG_TOLERANCE:       tol_q <= cfg_wdata_i[TOL_W-1:0];
      endcase
    end
  end

  assign in_if.ready = (state_q == ST_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign load_ok     = 32'(in_if.ref_index) < 32'(MAX_TEMPLATE_LEN);

  // threshold less tolerance, clamped at zero
  logic [DIST_BITS-1:0] tol_ext;
  logic [DIST_BITS-1:0] bar_d;
  always_comb begin
    tol_ext = DIST_BITS'(tol_q);
    bar_d   = (in_if.threshold_dist > tol_ext) ? in_if.threshold_dist - tol_ext : '0;
  end

  // ---------------- stage B: squared difference, pre-select -------------------
  logic [SAMPLE_BITS-1:0] ux, ur, diff;
  logic [SQW-1:0]         sq;
  logic [XW-1:0]          sq_wide;
  logic [DIST_BITS-1:0]   sq_sat;
  logic                   diag_le_old;
  logic                   ovl;
  logic                   below;
  always_comb begin
    ux          = x_q ^ SMP_SIGN;
    ur          = rd_tmpl_q ^ SMP_SIGN;
    diff        = (ux > ur) ? ux - ur : ur - ux;
    sq          = SQW'(diff) * SQW'(diff);
    sq_wide     = XW'(sq);
    sq_sat      = (sq_wide > XW'(DIST_INF)) ? DIST_INF : DIST_BITS'(sq);
    diag_le_old = (diag_d_q <= rd_dist_q);
    ovl         = found_q || (rd_start_q <= tend_q);
    below       = (rd_dist_q < bar_q);
  end

  // ---------------- stage C: best predecessor plus local distance -------------
  logic                 take_c;
  logic [DIST_BITS-1:0] best_d;
  logic [TIME_W-1:0]    best_s;
  logic [DIST_BITS:0]   sum;
  logic [DIST_BITS-1:0] new_d;
  logic [TIME_W-1:0]    new_s;
  always_comb begin
    // diag wins ties against up; old must be strictly smaller
    take_c = s2_c_diag_q ? (s2_c_d_q <= up_d_q) : (s2_c_d_q < up_d_q);
    best_d = take_c ? s2_c_d_q : up_d_q;
    best_s = take_c ? s2_c_s_q : up_s_q;
    sum    = {1'b0, best_d} + {1'b0, s2_sq_q};
    if (s2_first_q) begin
      new_d = s2_sq_q;
      new_s = t_q;
    end else begin
      new_d = sum[DIST_BITS] ? DIST_INF : sum[DIST_BITS-1:0];
      new_s = best_s;
    end
  end

  // ---------------- column write port ----------------------------------------
  logic                 dist_we, start_we;
  logic [AW-1:0]        dist_waddr, start_waddr;
  logic [DIST_BITS-1:0] dist_wdata;
  logic [TIME_W-1:0]    start_wdata;
  always_comb begin
    dist_we     = 1'b0;
    dist_waddr  = s2_idx_q;
    dist_wdata  = new_d;
    start_we    = 1'b0;
    start_waddr = s2_idx_q;
    start_wdata = new_s;
    priority if (state_q == ST_CLEAR) begin
      dist_we     = 1'b1;
      dist_waddr  = clr_q;
      dist_wdata  = DIST_INF;
      start_we    = 1'b1;
      start_waddr = clr_q;
      start_wdata = '0;
    end else if (s2_vld_q) begin
      dist_we  = 1'b1;
      start_we = 1'b1;
    end else if (s1_vld_q && op_q == REQ_PURGE && ovl && (all_q || !below)) begin
      dist_we    = 1'b1;
      dist_waddr = s1_idx_q;
      dist_wdata = DIST_INF;
    end
  end

  assign rd_addr = (state_q == ST_SCAN) ? idx_q : last_idx;

  always_ff @(posedge clk_i) begin
    if (in_fire && in_if.req_type == REQ_LOAD && load_ok) begin
      tmpl_mem[AW'(in_if.ref_index)] <= in_if.ref_value;
    end
    rd_tmpl_q <= tmpl_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (dist_we) begin
      dist_mem[dist_waddr] <= dist_wdata;
    end
    rd_dist_q <= dist_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (start_we) begin
      start_mem[start_waddr] <= start_wdata;
    end
    rd_start_q <= start_mem[rd_addr];
  end

  // ---------------- sequencer ------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (clr_q == LAST_ENTRY) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (in_if.req_type == REQ_LOAD) ? ST_DRAIN : ST_SCAN;
        end
      end
      ST_SCAN:   if (idx_q == last_idx) state_d = ST_DRAIN;
      ST_DRAIN:  if (!s1_vld_q && !s2_vld_q) state_d = ST_RESULT;
      ST_RESULT: if (!out_vld_q || out_if.ready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  assign out_load = (state_q == ST_RESULT) && (!out_vld_q || out_if.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      idx_q     <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      found_q   <= 1'b0;
      opt_q     <= 1'b0;
      op_q      <= REQ_LOAD;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (state_q == ST_SCAN) begin
        idx_q <= idx_q + AW'(1);
      end
      s1_vld_q <= (state_q == ST_SCAN);
      s2_vld_q <= s1_vld_q && (op_q == REQ_SAMPLE);
      if (in_fire) begin
        idx_q   <= '0;
        found_q <= 1'b0;
        op_q    <= in_if.req_type;
        opt_q   <= (in_if.req_type == REQ_CHECK);
      end else if (s1_vld_q) begin
        if (ovl) found_q <= 1'b1;
        if (op_q == REQ_CHECK && ovl && below) opt_q <= 1'b0;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q    <= in_if.sample_value;
      t_q    <= in_if.sample_time;
      tend_q <= in_if.overlap_end_time;
      bar_q  <= bar_d;
      all_q  <= in_if.purge_all;
    end
    s1_idx_q   <= idx_q;
    s1_first_q <= (idx_q == '0);
    if (s1_vld_q) begin
      s2_idx_q    <= s1_idx_q;
      s2_first_q  <= s1_first_q;
      s2_sq_q     <= sq_sat;
      s2_c_diag_q <= diag_le_old;
      s2_c_d_q    <= diag_le_old ? diag_d_q : rd_dist_q;
      s2_c_s_q    <= diag_le_old ? diag_s_q : rd_start_q;
      diag_d_q    <= rd_dist_q;
      diag_s_q    <= rd_start_q;
    end
    if (s2_vld_q) begin
      up_d_q <= new_d;
      up_s_q <= new_s;
    end
    if (out_load) begin
      out_dist_q  <= rd_dist_q;
      out_start_q <= rd_start_q;
      out_opt_q   <= opt_q;
    end
  end

  assign out_if.valid           = out_vld_q;
  assign out_if.end_dist        = out_dist_q;
  assign out_if.end_start_time  = out_start_q;
  assign out_if.locally_optimal = out_opt_q;

  // ---------------- assertions -----------------------------------------------
  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!s1_vld_q && !s2_vld_q))
    else $error("cell pipeline busy while idle");

  a_result_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESULT) |-> (!s1_vld_q && !s2_vld_q && !dist_we && !start_we))
    else $error("column written while result is read");

  a_opt_only_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    opt_q |-> (op_q == REQ_CHECK))
    else $error("optimality flag set outside a check");

  a_cells_in_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vld_q && $past(s2_vld_q)) |-> (s2_idx_q == $past(s2_idx_q) + AW'(1)))
    else $error("cell pipeline skipped an index");

  a_first_cell_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vld_q && !$past(s2_vld_q)) |-> (s2_first_q && s2_idx_q == '0))
    else $error("column update did not start at index zero");

endmodule

`default_nettype wire
